[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the UART transmitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni of the enclosing module.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/utx_pkg.sv]
// Types and constants of the 8N1 UART transmitter.
`default_nettype none
package utx_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned PreCntW   = 10;
  localparam int unsigned DivW      = 11;
  localparam int unsigned DataBits  = 8;
  localparam int unsigned BitIdxW   = 3;
  localparam int unsigned OutDataW  = 8;

  // Register indexes of the configuration channel.
  localparam logic [CfgIdxW-1:0] RegPrescaleSel = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCompareTop  = 2'd1;

  // Prescaler select codes.
  localparam logic [2:0] PreDiv1    = 3'd0;
  localparam logic [2:0] PreDiv8    = 3'd1;
  localparam logic [2:0] PreDiv64   = 3'd2;
  localparam logic [2:0] PreDiv256  = 3'd3;

  // Input item kinds.
  localparam logic ReqTick  = 1'b0;
  localparam logic ReqOffer = 1'b1;

  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhStart = 4'b0010,
    PhData  = 4'b0100,
    PhStop  = 4'b1000
  } phase_e;

  // Tick division of a prescaler code; unused codes divide by 1024.
  function automatic logic [DivW-1:0] prescale_div(input logic [2:0] sel);
    logic [DivW-1:0] div;
    unique case (sel)
      PreDiv1:   div = 11'd1;
      PreDiv8:   div = 11'd8;
      PreDiv64:  div = 11'd64;
      PreDiv256: div = 11'd256;
      default:   div = 11'd1024;
    endcase
    return div;
  endfunction

endpackage
`default_nettype wire

[rtl/uart_transmitter_8n1_core.sv]
// Transmit-only 8N1 UART core driven by a stream of tick and byte items.
//
// Input stream: each transfer is one item. tuser selects the kind: 0 is one
// tick of the baud timebase, 1 offers tdata as a byte to send. A byte is
// taken straight into the shifter when the line is idle, into the one-byte
// holding register while a frame is out, and refused when that is full.
// Output stream: one registered result per item, valid in the cycle after the
// input transfer: line level, busy flag and whether an offered byte was taken.
// A bit lasts prescale * (compare_top + 1) ticks.
// Throughput is one item per cycle while not stalled; all per-item work sits
// between the timer/shifter state registers and the single output register.
// The input ready is high whenever the output register is empty or being
// drained, so a stalled receiver holds off new items after exactly one
// result is parked; nothing is dropped.
// Configuration writes are always ready and take effect on the next item.
// Reset clears the timebase, sets the line idle (high) and empties the
// holding register and the output register.
`default_nettype none
module uart_transmitter_8n1_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                         s_axis_tuser_i,   // [0] req_type
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [0] tx_level, [1] busy_res, [2] byte_accepted, [7:3] zero
  output logic [utx_pkg::OutDataW-1:0]      m_axis_tdata_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [utx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [utx_pkg::CfgDataW-1:0] cfg_data_i
);
  import utx_pkg::*;

  logic [2:0]          presel_q;
  logic [7:0]          top_q;
  logic [PreCntW-1:0]  pre_cnt_q, pre_cnt_d;
  logic [7:0]          tmr_q, tmr_d;
  logic [7:0]          shift_q, shift_d;
  logic [BitIdxW-1:0]  idx_q, idx_d;
  phase_e              phase_q, phase_d;
  logic [7:0]          hold_q, hold_d;
  logic                hold_vld_q, hold_vld_d;
  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q;

  logic                in_xfer;
  logic                accepted;
  logic                level;
  logic [DivW-1:0]     pre_next;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign pre_next        = {1'b0, pre_cnt_q} + 11'd1;

  always_comb begin
    pre_cnt_d  = pre_cnt_q;
    tmr_d      = tmr_q;
    shift_d    = shift_q;
    idx_d      = idx_q;
    phase_d    = phase_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    accepted   = 1'b0;
    if (s_axis_tuser_i == ReqTick) begin
      if (phase_q != PhIdle) begin
        if (pre_next < prescale_div(presel_q)) begin
          pre_cnt_d = pre_next[PreCntW-1:0];
        end else begin
          pre_cnt_d = '0;
          if (tmr_q < top_q) begin
            tmr_d = tmr_q + 8'd1;
          end else begin
            tmr_d = '0;
            // End of one bit time: advance through the frame.
            unique case (phase_q)
              PhStart: begin
                phase_d = PhData;
                idx_d   = '0;
              end
              PhData: begin
                idx_d = idx_q + 3'd1;
                if (idx_q == BitIdxW'(DataBits - 1)) begin
                  phase_d = PhStop;
                end
              end
              default: begin
                if (hold_vld_q) begin
                  hold_vld_d = 1'b0;
                  shift_d    = hold_q;
                  idx_d      = '0;
                  phase_d    = PhStart;
                  pre_cnt_d  = '0;
                end else begin
                  phase_d = PhIdle;
                  idx_d   = '0;
                end
              end
            endcase
          end
        end
      end
    end else if (!hold_vld_q) begin
      accepted = 1'b1;
      if (phase_q == PhIdle) begin
        shift_d   = s_axis_tdata_i;
        idx_d     = '0;
        phase_d   = PhStart;
        pre_cnt_d = '0;
        tmr_d     = '0;
      end else begin
        hold_d     = s_axis_tdata_i;
        hold_vld_d = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (phase_d)
      PhStart: level = 1'b0;
      PhData:  level = shift_d[idx_d];
      default: level = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presel_q <= '0;
      top_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegPrescaleSel) begin
        presel_q <= cfg_data_i[2:0];
      end else if (cfg_index_i == RegCompareTop) begin
        top_q <= cfg_data_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q  <= '0;
      tmr_q      <= '0;
      shift_q    <= '0;
      idx_q      <= '0;
      phase_q    <= PhIdle;
      hold_vld_q <= 1'b0;
    end else if (in_xfer) begin
      pre_cnt_q  <= pre_cnt_d;
      tmr_q      <= tmr_d;
      shift_q    <= shift_d;
      idx_q      <= idx_d;
      phase_q    <= phase_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  // The holding byte is only read while its valid flag is set.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_xfer) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {5'd0, accepted, (phase_d != PhIdle) || hold_vld_d, level};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

[rtl/utx_checker.sv]
// Port-level assertions for the UART transmitter core and their bind.
`default_nettype none
`include "assert_macros.svh"
module utx_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  // A parked result must not change until it is transferred.
  `ASSERT_STD(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "output changed while stalled")

  // Every accepted item yields a result in the next cycle.
  `ASSERT_STD(a_in_to_out, s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o, "accepted item produced no result")

  // A taken byte always leaves the transmitter busy.
  `ASSERT_STD(a_accept_busy, m_axis_tvalid_o && m_axis_tdata_o[2] |-> m_axis_tdata_o[1], "byte taken but not busy")

  // The line is only driven low during a frame.
  `ASSERT_STD(a_low_busy, m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[1], "line low while idle")

endmodule

bind uart_transmitter_8n1_core utx_checker u_utx_checker (.*);
`default_nettype wire
